[sv/amt_pkg.sv]
`timescale 1ns / 1ps

package amt_pkg;

    localparam int DIV_NUM_W = 21;   // quotient width of 2^20 / n
    localparam int DIV_DEN_W = 14;   // window area up to 127 * 127

    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;
    localparam logic [1:0] CFG_BIAS_Q10      = 2'd3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_GEO,
        S_Q_RD,
        S_Q_MUL,
        S_Q_WAIT,
        S_Q_THR,
        S_Q_FIN
    } t_state;

endpackage

[sv/amt_div.sv]
`timescale 1ns / 1ps

module amt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [amt_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic [amt_pkg::DIV_NUM_W-1:0] o_quo
);
    import amt_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    // numerator is 2^20: only its top bit is set
    always_comb begin
        rem_sh = {r_rem, (r_cnt == '0)};
        fits   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

[sv/amt_store.sv]
`timescale 1ns / 1ps

module amt_store #(
    parameter int DEPTH = 76800,
    parameter int AW    = 17
) (
    input  logic          i_clk,
    input  logic          i_int_we,
    input  logic [AW-1:0] i_int_waddr,
    input  logic [31:0]   i_int_wdata,
    input  logic [AW-1:0] i_int_raddr,
    output logic [31:0]   o_int_rdata,
    input  logic          i_pix_we,
    input  logic [AW-1:0] i_pix_waddr,
    input  logic [7:0]    i_pix_wdata,
    input  logic [AW-1:0] i_pix_raddr,
    output logic [7:0]    o_pix_rdata
);
    logic [31:0] int_mem [DEPTH];
    logic [7:0]  pix_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_int_we) begin
            int_mem[i_int_waddr] <= i_int_wdata;
        end
        o_int_rdata <= int_mem[i_int_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_we) begin
            pix_mem[i_pix_waddr] <= i_pix_wdata;
        end
        o_pix_rdata <= pix_mem[i_pix_raddr];
    end

endmodule

[sv/adaptive_mean_threshold_core.sv]
`timescale 1ns / 1ps
// Load item: accept, read the entry above, write back the integral entry.
// Query item: geometry, a four-read integral fetch from a single-port-read memory, multiply,
// a wait on the 21-step bit-serial reciprocal divider started during the fetch, threshold and
// finish. One item is worked at a time; the output register frees the input while a result
// waits. Reset (synchronous, active low) clears control, configuration registers and row sum;
// the stores are not cleared and hold undefined data until loaded.
module adaptive_mean_threshold_core #(
    parameter int MAX_WIDTH  = 320,
    parameter int MAX_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_value[7:0], col[16:8], row[24:17]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // is_white[0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data
);
    import amt_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [12:0] MW13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MH13 = 13'(MAX_HEIGHT);

    function automatic logic [AW-1:0] f_addr(input logic [7:0] y, input logic [8:0] x);
        f_addr = AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
    endfunction

    // configuration
    logic [8:0]  r_cfg_w;
    logic [7:0]  r_cfg_h;
    logic [5:0]  r_rad;
    logic [11:0] r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd320;
            r_cfg_h <= 8'd240;
            r_rad   <= 6'd10;
            r_bias  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH:   r_cfg_w <= i_cfg_data[8:0];
                CFG_FRAME_HEIGHT:  r_cfg_h <= i_cfg_data[7:0];
                CFG_WINDOW_RADIUS: r_rad   <= i_cfg_data[5:0];
                CFG_BIAS_Q10:      r_bias  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [8:0] eff_w;
    logic [7:0] eff_h;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = 9'd1;
        end else if ({4'b0, r_cfg_w} > MW13) begin
            eff_w = 9'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            eff_h = 8'd1;
        end else if ({5'b0, r_cfg_h} > MH13) begin
            eff_h = 8'(MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    // input fields
    logic [7:0] in_pix;
    logic [8:0] in_col;
    logic [7:0] in_row;
    logic       in_frame;

    assign in_pix   = s_axis_tdata[7:0];
    assign in_col   = s_axis_tdata[16:8];
    assign in_row   = s_axis_tdata[24:17];
    assign in_frame = (in_col < eff_w) && (in_row < eff_h);

    t_state r_state, n_state;

    logic [7:0]  r_pix;
    logic [8:0]  r_col;
    logic [7:0]  r_row;
    logic [31:0] r_rsum;
    logic [7:0]  r_y0, r_y1;
    logic [8:0]  r_x0, r_x1;
    logic [6:0]  r_cy, r_cx;
    logic        r_border, r_inner;
    logic [2:0]  r_k;
    logic        r_zpend;
    logic        r_neg;
    logic [31:0] r_sum;
    logic [13:0] r_den;
    logic [13:0] r_area;
    logic [7:0]  r_v;
    logic [31:0] r_prod;
    logic [21:0] r_vc;
    logic [31:0] r_tprod;
    logic        r_res;
    logic        r_out_valid;
    logic        r_out_data;

    // store ports
    logic          int_we, pix_we;
    logic [AW-1:0] int_waddr, int_raddr, pix_waddr, pix_raddr;
    logic [31:0]   int_wdata, int_rdata;
    logic [7:0]    pix_rdata;
    logic          div_start, div_busy;
    logic [20:0]   div_quo;

    // geometry
    logic [8:0]  y1_raw;
    logic [9:0]  x1_raw;
    logic [7:0]  g_y0, g_y1;
    logic [8:0]  g_x0, g_x1;
    logic        g_border, g_inner;
    logic [6:0]  full;
    logic [7:0]  q_y;
    logic [8:0]  q_x;
    logic        q_zero;
    logic [31:0] rsum_next;
    logic [21:0] scaled;
    logic        accept, fin_load;

    always_comb begin
        g_y0     = (r_row > {2'b0, r_rad}) ? r_row - {2'b0, r_rad} : '0;
        y1_raw   = {1'b0, r_row} + {3'b0, r_rad} + 9'd1;
        g_y1     = (y1_raw > {1'b0, eff_h}) ? eff_h : y1_raw[7:0];
        g_x0     = (r_col > {3'b0, r_rad}) ? r_col - {3'b0, r_rad} : '0;
        x1_raw   = {1'b0, r_col} + {4'b0, r_rad} + 10'd1;
        g_x1     = (x1_raw > {1'b0, eff_w}) ? eff_w : x1_raw[8:0];
        g_border = (r_col < {3'b0, r_rad}) || (({1'b0, r_col} + {4'b0, r_rad}) >= {1'b0, eff_w});
        g_inner  = (r_row >= {2'b0, r_rad}) && (({1'b0, r_row} + {3'b0, r_rad}) < {1'b0, eff_h});
        full     = {r_rad, 1'b1};
    end

    // corner order: (y1,x1) +, (y1,x0) -, (y0,x1) -, (y0,x0) +
    always_comb begin
        unique case (r_k)
            3'd0:    begin q_y = r_y1; q_x = r_x1; end
            3'd1:    begin q_y = r_y1; q_x = r_x0; end
            3'd2:    begin q_y = r_y0; q_x = r_x1; end
            default: begin q_y = r_y0; q_x = r_x0; end
        endcase
        q_zero = (q_y == '0) || (q_x == '0);
    end

    assign rsum_next = (r_col == '0) ? {24'b0, r_pix} : r_rsum + {24'b0, r_pix};
    assign scaled    = r_prod[31:10];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign fin_load  = (r_state == S_Q_FIN) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state   = r_state;
        int_we    = 1'b0;
        int_waddr = f_addr(r_row, r_col);
        int_wdata = rsum_next + ((r_row == '0) ? 32'd0 : int_rdata);
        int_raddr = f_addr(r_row - 8'd1, r_col);
        pix_we    = 1'b0;
        pix_waddr = f_addr(r_row, r_col);
        pix_raddr = f_addr(r_row, r_col);
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (s_axis_tuser == REQ_QUERY) begin
                        n_state = in_frame ? S_Q_GEO : S_Q_FIN;
                    end else if (in_frame) begin
                        n_state = S_LD_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LD_RD: begin
                pix_we  = 1'b1;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                int_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_Q_GEO: n_state = S_Q_RD;
            S_Q_RD: begin
                int_raddr = f_addr(q_y - 8'd1, q_x - 9'd1);
                div_start = (r_k == 3'd1);
                if (r_k == 3'd4) begin
                    n_state = S_Q_MUL;
                end
            end
            S_Q_MUL:  n_state = S_Q_WAIT;
            S_Q_WAIT: begin
                if (!div_busy) begin
                    n_state = S_Q_THR;
                end
            end
            S_Q_THR: n_state = S_Q_FIN;
            S_Q_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsum      <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (r_state == S_LD_WR) begin
                r_rsum <= rsum_next;
            end
            if (r_state == S_Q_GEO) begin
                r_k <= '0;
            end else if (r_state == S_Q_RD) begin
                r_k <= r_k + 3'd1;
            end
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= in_pix;
            r_col <= in_col;
            r_row <= in_row;
            r_res <= 1'b0;
        end
        if (r_state == S_Q_GEO) begin
            r_y0     <= g_y0;
            r_y1     <= g_y1;
            r_x0     <= g_x0;
            r_x1     <= g_x1;
            r_cy     <= 7'(g_y1 - g_y0);
            r_cx     <= 7'(g_x1 - g_x0);
            r_border <= g_border;
            r_inner  <= g_inner;
            r_sum    <= '0;
        end
        if (r_state == S_Q_RD) begin
            r_zpend <= q_zero;
            r_neg   <= (r_k == 3'd1) || (r_k == 3'd2);
            if (r_k != 3'd0) begin
                if (!r_zpend) begin
                    r_sum <= r_neg ? r_sum - int_rdata : r_sum + int_rdata;
                end
            end else begin
                r_den  <= r_inner ? 14'(full * full) : 14'(full * r_cy);
                r_area <= 14'(r_cx * r_cy);
            end
            if (r_k == 3'd1) begin
                r_v <= pix_rdata;
            end
        end
        if (r_state == S_Q_MUL) begin
            r_prod <= r_sum * (32'd1024 - {{20{r_bias[11]}}, r_bias});
            r_vc   <= 22'(r_v * r_area);
        end
        if ((r_state == S_Q_WAIT) && !div_busy) begin
            r_tprod <= 32'({10'b0, scaled} * {11'b0, div_quo});
        end
        if (r_state == S_Q_THR) begin
            r_res <= r_border ? (r_vc > scaled) : ({4'b0, r_v} > r_tprod[31:20]);
        end
        if (fin_load) begin
            r_out_data <= r_res;
        end
    end

    amt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_int_we    (int_we),
        .i_int_waddr (int_waddr),
        .i_int_wdata (int_wdata),
        .i_int_raddr (int_raddr),
        .o_int_rdata (int_rdata),
        .i_pix_we    (pix_we),
        .i_pix_waddr (pix_waddr),
        .i_pix_wdata (r_pix),
        .i_pix_raddr (pix_raddr),
        .o_pix_rdata (pix_rdata)
    );

    amt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_data};

`ifndef ASSERT_OFF
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_Q_FIN))
        else $error("result appeared outside the finish step");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_int_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int_we |-> $past(r_state == S_LD_RD))
        else $error("integral write without prior read of the entry above");
`endif

endmodule

[bench/adaptive_mean_threshold_core_tb.sv]
`timescale 1ns / 1ps

module adaptive_mean_threshold_core_tb;
    import amt_pkg::*;

    localparam int ROW_PITCH   = 320;
    localparam int STORE_SIZE  = 320 * 240;
    localparam int CYCLE_LIMIT = 600000;

    // Integral-image thresholder: own copy of stores, row sum and registers.
    class threshold_tracker;
        bit [31:0] integ [0:STORE_SIZE-1];
        bit [7:0]  pix   [0:STORE_SIZE-1];
        bit [31:0] row_sum;
        bit [8:0]  width_reg;
        bit [7:0]  height_reg;
        bit [5:0]  radius_reg;
        bit [31:0] bias_reg;
        bit        pending_white[$];

        function new();
            row_sum    = 32'd0;
            width_reg  = 9'd320;
            height_reg = 8'd240;
            radius_reg = 6'd10;
            bias_reg   = 32'd0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [11:0] val);
            case (idx)
                CFG_FRAME_WIDTH:   width_reg  = val[8:0];
                CFG_FRAME_HEIGHT:  height_reg = val[7:0];
                CFG_WINDOW_RADIUS: radius_reg = val[5:0];
                CFG_BIAS_Q10:      bias_reg   = {{20{val[11]}}, val};
                default: ;
            endcase
        endfunction

        function bit [31:0] eff_w();
            if (width_reg == 0) return 32'd1;
            if (width_reg > 320) return 32'd320;
            return 32'(width_reg);
        endfunction

        function bit [31:0] eff_h();
            if (height_reg == 0) return 32'd1;
            if (height_reg > 240) return 32'd240;
            return 32'(height_reg);
        endfunction

        function bit [31:0] integ_at(bit [31:0] y, bit [31:0] x);
            if (y == 0 || x == 0) return 32'd0;
            return integ[(y - 1) * ROW_PITCH + (x - 1)];
        endfunction

        function bit white_for(bit [31:0] c, bit [31:0] r);
            bit [31:0] w, h, rad, y0, y1, x0, x1, cy, cx, sum, v, rhs, scaled, full, inv, thr;
            w = eff_w();
            h = eff_h();
            rad = 32'(radius_reg);
            if (c >= w || r >= h) return 1'b0;
            y0 = (r > rad) ? r - rad : 32'd0;
            y1 = r + rad + 1;
            if (y1 > h) y1 = h;
            x0 = (c > rad) ? c - rad : 32'd0;
            x1 = c + rad + 1;
            if (x1 > w) x1 = w;
            cy = y1 - y0;
            cx = x1 - x0;
            sum = integ_at(y1, x1) - integ_at(y1, x0) - integ_at(y0, x1) + integ_at(y0, x0);
            v = 32'(pix[r * ROW_PITCH + c]);
            rhs = 32'd1024 - bias_reg;
            scaled = (sum * rhs) >> 10;
            full = 2 * rad + 1;
            if (c < rad || c + rad >= w) return (v * (cx * cy)) > scaled;
            if (r >= rad && r + rad < h) inv = 32'h0010_0000 / (full * full);
            else inv = 32'h0010_0000 / (full * cy);
            thr = (scaled * inv) >> 20;
            return v > thr;
        endfunction

        function void note_item(bit kind, bit [7:0] v, bit [8:0] c, bit [7:0] r);
            int idx;
            if (kind == REQ_QUERY) begin
                pending_white.push_back(white_for(32'(c), 32'(r)));
                return;
            end
            if (c >= eff_w() || r >= eff_h()) return;
            if (c == 0) row_sum = 32'(v);
            else row_sum = row_sum + 32'(v);
            idx = r * ROW_PITCH + c;
            integ[idx] = row_sum + integ_at(32'(r), 32'(c) + 32'd1);
            pix[idx] = v;
        endfunction

        // Returns 0 when no result is waiting.
        function bit check_result(output bit want);
            if (pending_white.size() == 0) return 1'b0;
            want = pending_white.pop_front();
            return 1'b1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [11:0] i_cfg_data;

    adaptive_mean_threshold_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    threshold_tracker tracker = new();
    int  mismatches = 0;
    int  sent_items = 0;
    int  cycles = 0;
    bit  no_idle = 0;
    int  sink_stall = 0;
    int  fw, fh;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL adaptive_mean_threshold_core");
            $finish;
        end
    end

    // Result side: random stall before each item, checked at the accepting edge.
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stall > 0) begin
                m_axis_tready = 0;
                sink_stall--;
            end else begin
                m_axis_tready = 1;
            end
        end
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (!tracker.check_result(want))
                report($sformatf("unexpected result %0h", m_axis_tdata));
            else if (m_axis_tdata !== {7'd0, want})
                report($sformatf("is_white got %0h want %0d", m_axis_tdata, want));
            sink_stall = no_idle ? 0 : int'($urandom_range(0, 6));
        end
    end

    task automatic send_item(bit kind, bit [7:0] v, bit [8:0] c, bit [7:0] r);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 6));
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {7'd0, r, c, v};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_item(kind, v, c, r);
        sent_items++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (tracker.pending_white.size() != 0) @(posedge i_clk);
        // let a trailing load finish its write-back
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [11:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic setup_frame(bit [11:0] w, bit [11:0] h, bit [11:0] rad, bit [11:0] bias);
        drain();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_WINDOW_RADIUS, rad);
        write_reg(CFG_BIAS_Q10, bias);
        fw = int'(tracker.eff_w());
        fh = int'(tracker.eff_h());
    endtask

    function automatic bit [7:0] pick_pixel(int style);
        case (style)
            0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            1: return 8'($urandom_range(200, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Raster load of the whole frame, with an occasional ignored item mixed in.
    task automatic load_frame(int style);
        for (int r = 0; r < fh; r++)
            for (int c = 0; c < fw; c++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(REQ_LOAD, 8'($urandom), 9'($urandom_range(fw, 511)),
                              8'($urandom));
                send_item(REQ_LOAD, pick_pixel(style), 9'(c), 8'(r));
            end
    endtask

    task automatic mixed_items(int count, int style);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = int'($urandom_range(0, 99));
            if (sel < 55)
                send_item(REQ_QUERY, 8'($urandom), 9'($urandom_range(0, fw - 1)),
                          8'($urandom_range(0, fh - 1)));
            else if (sel < 65)
                send_item(REQ_QUERY, 8'($urandom), 9'($urandom), 8'($urandom));
            else if (sel < 90)
                send_item(REQ_LOAD, pick_pixel(style), 9'($urandom_range(0, fw - 1)),
                          8'($urandom_range(0, fh - 1)));
            else
                send_item(REQ_LOAD, 8'($urandom), 9'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        bit [11:0] bias;
        i_rst_n       = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tuser  = 0;
        i_cfg_we      = 0;
        i_cfg_addr    = 0;
        i_cfg_data    = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // small frame: every pixel queried, plus queries off the frame
        setup_frame(4, 3, 1, 12'hE00);
        no_idle = 1;
        load_frame(0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                send_item(REQ_QUERY, 8'hFF, 9'(c), 8'(r));
        send_item(REQ_QUERY, 8'd0, 9'd4, 8'd0);
        send_item(REQ_QUERY, 8'd0, 9'd511, 8'd255);
        no_idle = 0;

        // zero sizes act as one pixel, largest radius, bias of -1024 (-1.0 in Q10)
        setup_frame(0, 0, 63, 12'hC00);
        load_frame(2);
        mixed_items(8, 2);

        // oversized width: one full-length row
        setup_frame(511, 1, 63, 12'h400);
        load_frame(2);
        mixed_items(20, 2);

        // tall single column, out-of-range bias
        setup_frame(1, 255, 3, 12'h7FF);
        load_frame(1);
        mixed_items(20, 1);

        setup_frame(1, 8, 0, 12'h800);
        load_frame(0);
        mixed_items(10, 0);

        while (sent_items < 800) begin
            bias = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 2200) - 1100);
            setup_frame(12'($urandom_range(1, 16)), 12'($urandom_range(1, 12)),
                        12'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 6)),
                        bias);
            no_idle = $urandom_range(0, 4) == 0;
            load_frame(int'($urandom_range(0, 3)));
            mixed_items(int'($urandom_range(20, 50)), int'($urandom_range(0, 3)));
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && tracker.pending_white.size() == 0) begin
            $display("PASS adaptive_mean_threshold_core");
        end else begin
            $display("FAIL adaptive_mean_threshold_core");
        end
        $finish;
    end

endmodule

[files.f]
sv/amt_pkg.sv
sv/amt_div.sv
sv/amt_store.sv
sv/adaptive_mean_threshold_core.sv
bench/adaptive_mean_threshold_core_tb.sv
